// ===== sv/spmd_pkg.sv =====
package spmd_pkg;

  // Decoder phase within one sprite
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEIGHT = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_ACCEPT = 4'b0001,
    ST_MUL1   = 4'b0010,
    ST_MUL2   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  localparam int unsigned SKIP_W = 22;
  localparam int unsigned PAGE_W = 5;

  // Controller to datapath
  typedef struct packed {
    logic take;     // input item accepted this cycle
    logic mul1;     // width * height
    logic mul2;     // size * frame, then phase decision
    logic emit;     // load one pixel into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic goes_mul;   // item at input is a height byte
    logic goes_emit;  // item at input is a nonzero mask byte
    logic out_free;   // output register can take a pixel
    logic one_left;   // one set bit left in the mask
    logic mask_nz;    // mask still has set bits
  } sts_t;

endpackage

// ===== sv/spmd_ctrl.sv =====
module spmd_ctrl
  import spmd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t st_r, st_nxt;

  always_comb begin
    st_nxt    = st_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (st_r)
      ST_ACCEPT: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && sts.goes_mul) begin
          st_nxt = ST_MUL1;
        end else if (in_tvalid && sts.goes_emit) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        st_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        st_nxt   = ST_ACCEPT;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.one_left) begin
          st_nxt = ST_ACCEPT;
        end
      end
      default: begin
        st_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_ACCEPT;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MUL1 |=> st_r == ST_MUL2)
    else $error("multiply sequence broken");
  a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EMIT |-> sts.mask_nz)
    else $error("emitting with empty mask");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_ACCEPT |-> !cmd.take)
    else $error("item taken while busy");
`endif

endmodule

// ===== sv/spmd_dpath.sv =====
module spmd_dpath
  import spmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [7:0] byte_in, ox_in, oy_in, frm_in;
  assign byte_in = in_tdata[7:0];
  assign ox_in   = in_tdata[15:8];
  assign oy_in   = in_tdata[23:16];
  assign frm_in  = in_tdata[31:24];

  phase_t              phase_r, phase_nxt;
  logic [7:0]          width_r, width_nxt;
  logic [7:0]          hgt_r, hgt_nxt;
  logic [PAGE_W-1:0]   ptot_r, ptot_nxt;
  logic [7:0]          frame_r, frame_nxt;
  logic [7:0]          ocol_r, ocol_nxt;
  logic [7:0]          orow_r, orow_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [15:0]         prod_r, prod_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [7:0]          col_r, col_nxt;
  logic [7:0]          color_r, color_nxt;
  logic                turn_r, turn_nxt;
  logic [7:0]          mask_r, mask_nxt;
  logic [7:0]          px_r, px_nxt;
  logic [7:0]          ybase_r, ybase_nxt;
  logic                ov_r, ov_nxt;
  logic [7:0]          ox_r, ox_nxt;
  logic [7:0]          oy_r, oy_nxt;
  logic                ow_r, ow_nxt;
  logic                ol_r, ol_nxt;

  logic [2:0]          bit_idx;
  logic [7:0]          mask_clr;
  logic [SKIP_W-1:0]   skip_dec;
  logic [7:0]          col_inc;
  logic [PAGE_W-1:0]   page_inc;

  // lowest set bit of the pending mask
  always_comb begin
    bit_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) bit_idx = 3'(i);
    end
  end

  assign mask_clr = mask_r & (mask_r - 8'd1);
  assign skip_dec = skip_r - SKIP_W'(1);
  assign col_inc  = col_r + 8'd1;
  assign page_inc = page_r + PAGE_W'(1);

  assign sts.goes_mul  = !in_tuser && (phase_r == PH_HEIGHT);
  assign sts.goes_emit = !in_tuser && (phase_r == PH_DATA) && turn_r && (byte_in != 8'd0);
  assign sts.out_free  = !ov_r || out_tready;
  assign sts.one_left  = (mask_clr == 8'd0);
  assign sts.mask_nz   = (mask_r != 8'd0);

  always_comb begin
    phase_nxt = phase_r;  width_nxt = width_r;  hgt_nxt   = hgt_r;
    ptot_nxt  = ptot_r;   frame_nxt = frame_r;  ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;   skip_nxt  = skip_r;   prod_nxt  = prod_r;
    page_nxt  = page_r;   col_nxt   = col_r;    color_nxt = color_r;
    turn_nxt  = turn_r;   mask_nxt  = mask_r;   px_nxt    = px_r;
    ybase_nxt = ybase_r;  ox_nxt    = ox_r;     oy_nxt    = oy_r;
    ow_nxt    = ow_r;     ol_nxt    = ol_r;
    ov_nxt    = ov_r && !out_tready;

    if (cmd.take) begin
      if (in_tuser) begin
        width_nxt = byte_in;
        ocol_nxt  = ox_in;
        orow_nxt  = oy_in;
        frame_nxt = frm_in;
        phase_nxt = PH_HEIGHT;
      end else begin
        case (phase_r)
          PH_HEIGHT: begin
            hgt_nxt   = byte_in;
            ptot_nxt  = byte_in[7:3];
            page_nxt  = '0;
            col_nxt   = '0;
            color_nxt = '0;
            turn_nxt  = 1'b0;
          end
          PH_SKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == '0) phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            if (!turn_r) begin
              color_nxt = byte_in;
              turn_nxt  = 1'b1;
            end else begin
              mask_nxt  = byte_in;
              px_nxt    = ocol_r + col_r;
              ybase_nxt = orow_r + {page_r, 3'b000};
              turn_nxt  = 1'b0;
              col_nxt   = col_inc;
              if (col_inc >= width_r) begin
                col_nxt  = '0;
                page_nxt = page_inc;
                if (page_inc >= ptot_r) phase_nxt = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.mul1) begin
      prod_nxt = 16'(width_r) * 16'(hgt_r);
    end

    if (cmd.mul2) begin
      // 14-bit size times 8-bit frame fills the 22-bit skip count exactly
      skip_nxt = SKIP_W'(prod_r[15:2]) * SKIP_W'(frame_r);
    end

    if (cmd.emit) begin
      ov_nxt   = 1'b1;
      ox_nxt   = px_r;
      oy_nxt   = ybase_r + {5'd0, bit_idx};
      ow_nxt   = color_r[bit_idx];
      ol_nxt   = (mask_clr == 8'd0);
      mask_nxt = mask_clr;
    end
  end

  // phase decision lands with the skip product; the product never wraps,
  // so it is zero exactly when size or frame is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      turn_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      turn_r   <= turn_nxt;
      ov_r     <= ov_nxt;
      if (cmd.mul2) begin
        if (width_r == 8'd0 || ptot_r == '0) begin
          phase_r <= PH_IDLE;
        end else if (prod_r[15:2] == '0 || frame_r == 8'd0) begin
          phase_r <= PH_DATA;
        end else begin
          phase_r <= PH_SKIP;
        end
      end else begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    width_r <= width_nxt;  hgt_r   <= hgt_nxt;    ptot_r  <= ptot_nxt;
    frame_r <= frame_nxt;  ocol_r  <= ocol_nxt;   orow_r  <= orow_nxt;
    skip_r  <= skip_nxt;   prod_r  <= prod_nxt;   page_r  <= page_nxt;
    col_r   <= col_nxt;    color_r <= color_nxt;  mask_r  <= mask_nxt;
    px_r    <= px_nxt;     ybase_r <= ybase_nxt;  ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;     ow_r    <= ow_nxt;     ol_r    <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tuser  = ow_r;
  assign out_tlast  = ol_r;

`ifndef SYNTHESIS
  a_emit_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> mask_r != 8'd0)
    else $error("pixel emitted from empty mask");
  a_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul2 |=> phase_r != PH_HEIGHT)
    else $error("height phase survived decision");
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && mask_clr == 8'd0 |=> mask_r == 8'd0 && out_tlast)
    else $error("last pixel not marked");
`endif

endmodule

// ===== sv/sprite_plus_mask_decoder_core.sv =====
// Channel  Direction  tdata (low bit up)                          tuser      tlast
// in_      slave      data_byte, origin_x, origin_y, frame_index  start_req  -
// out_     master     pixel_x, pixel_y                            white      last_of_run
//
// Steps: header, skip, colour and zero-mask bytes pass through accept alone; the height
//   byte through accept, width*height multiply and size*frame multiply, the phase settled
//   together with the skip count; a mask byte is accepted, then emits one pixel per set bit.
// Reset: rst_n synchronous, active low; decoder returns to idle, output empty.
// Stalls: out_tready low holds the pixel register and pauses the bit walk; a new
//   byte is taken while the last pixel of the previous byte waits at the output.
module sprite_plus_mask_decoder_core
  import spmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte, origin_x, origin_y, frame_index
  input  logic        in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_x, pixel_y
  output logic        out_tuser,  // white
  output logic        out_tlast   // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: accept, two multiply steps, per-bit pixel walk
  spmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // sprite state, skip counter, mask walk and output register
  spmd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
